/* rtl/core/pfr_pkg.sv */
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and codes for the page frame replacement unit
// result codes, policy codes, controller states and the control groups
// of the search token and the write command of the frame chain
// ----------------------------------------------------------------------------
package pfr_pkg;

	localparam int OUTCOME_BITS = 2;
	localparam int POLICY_BITS  = 2;

	localparam logic [OUTCOME_BITS-1:0] OUT_HIT   = 2'd0;
	localparam logic [OUTCOME_BITS-1:0] OUT_FREE  = 2'd1;
	localparam logic [OUTCOME_BITS-1:0] OUT_EVICT = 2'd2;

	localparam logic [POLICY_BITS-1:0] POL_FIFO = 2'd0;
	localparam logic [POLICY_BITS-1:0] POL_LRU  = 2'd1;
	localparam logic [POLICY_BITS-1:0] POL_SC   = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_LAUNCH = 4'b0010,
		S_WAIT   = 4'b0100,
		S_EMIT   = 4'b1000
	} pfr_state_t;

	// flags of the search token handed from cell to cell
	typedef struct packed {
		logic valid;
		logic hit;
		logic free;
		logic old_have;
		logic old_ref;
	} pfr_tok_flags_t;

	// flags of the write command broadcast to all cells
	typedef struct packed {
		logic en;
		logic fill;
		logic wr_stamp;
		logic wr_ref;
		logic ref_val;
	} pfr_cmd_flags_t;

endpackage

/* rtl/core/pfr_if.sv */
// ----------------------------------------------------------------------------
// pfr channel interfaces
// request, result and policy write channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface pfr_req_if #(
	parameter int PAGE_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page;

	modport source (output valid, output page, input ready);
	modport sink   (input valid, input page, output ready);
endinterface

interface pfr_res_if #(
	parameter int PAGE_BITS  = 16,
	parameter int FRAME_BITS = 2
);
	logic                              valid;
	logic                              ready;
	logic [pfr_pkg::OUTCOME_BITS-1:0]  outcome;
	logic [FRAME_BITS-1:0]             frame;
	logic [PAGE_BITS-1:0]              evicted_page;

	modport source (output valid, output outcome, output frame, output evicted_page,
		input ready);
	modport sink   (input valid, input outcome, input frame, input evicted_page,
		output ready);
endinterface

interface pfr_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [pfr_pkg::POLICY_BITS-1:0]  policy;

	modport source (output valid, output policy, input ready);
	modport sink   (input valid, input policy, output ready);
endinterface

/* rtl/core/pfr_cell.sv */
// ----------------------------------------------------------------------------
// pfr_cell: one frame of the chain
// holds page, valid, stamp and reference bit; folds its frame into the
// passing search token and registers it towards the next cell
// ----------------------------------------------------------------------------
module pfr_cell #(
	parameter int FRAMES     = 4,
	parameter int PAGE_BITS  = 16,
	parameter int STAMP_BITS = 32,
	parameter int IDX        = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pfr_pkg::pfr_tok_flags_t           tin_flags,
	input  logic [PAGE_BITS-1:0]              tin_page,
	input  logic [$clog2(FRAMES)-1:0]         tin_hit_idx,
	input  logic [$clog2(FRAMES)-1:0]         tin_free_idx,
	input  logic [$clog2(FRAMES)-1:0]         tin_old_idx,
	input  logic [STAMP_BITS-1:0]             tin_old_stamp,
	input  logic [PAGE_BITS-1:0]              tin_old_page,
	output pfr_pkg::pfr_tok_flags_t           tout_flags,
	output logic [PAGE_BITS-1:0]              tout_page,
	output logic [$clog2(FRAMES)-1:0]         tout_hit_idx,
	output logic [$clog2(FRAMES)-1:0]         tout_free_idx,
	output logic [$clog2(FRAMES)-1:0]         tout_old_idx,
	output logic [STAMP_BITS-1:0]             tout_old_stamp,
	output logic [PAGE_BITS-1:0]              tout_old_page,
	input  pfr_pkg::pfr_cmd_flags_t           cmd_flags,
	input  logic [$clog2(FRAMES)-1:0]         cmd_idx,
	input  logic [PAGE_BITS-1:0]              cmd_page,
	input  logic [STAMP_BITS-1:0]             cmd_stamp
);
	import pfr_pkg::*;

	localparam int FB = $clog2(FRAMES);
	localparam logic [FB-1:0] MY_IDX = FB'(IDX);

	logic [PAGE_BITS-1:0]  page_q;
	logic                  valid_q;
	logic [STAMP_BITS-1:0] stamp_q;
	logic                  ref_q;

	pfr_tok_flags_t        nflags;
	logic [FB-1:0]         nhit_idx, nfree_idx, nold_idx;
	logic [STAMP_BITS-1:0] nold_stamp;
	logic [PAGE_BITS-1:0]  nold_page;
	logic                  sel;

	assign sel = cmd_flags.en && (cmd_idx == MY_IDX);

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			stamp_q <= STAMP_BITS'(IDX + 1);
			ref_q   <= 1'b0;
		end else if (sel) begin
			if (cmd_flags.fill) begin
				valid_q <= 1'b1;
			end
			if (cmd_flags.wr_stamp) begin
				stamp_q <= cmd_stamp;
			end
			if (cmd_flags.wr_ref) begin
				ref_q <= cmd_flags.ref_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd_flags.fill) begin
			page_q <= cmd_page;
		end
	end

	// fold this frame into the token; earlier cells win ties
	always_comb begin
		nflags     = tin_flags;
		nhit_idx   = tin_hit_idx;
		nfree_idx  = tin_free_idx;
		nold_idx   = tin_old_idx;
		nold_stamp = tin_old_stamp;
		nold_page  = tin_old_page;
		if (!tin_flags.hit && valid_q && (page_q == tin_page)) begin
			nflags.hit = 1'b1;
			nhit_idx   = MY_IDX;
		end
		if (!tin_flags.free && !valid_q) begin
			nflags.free = 1'b1;
			nfree_idx   = MY_IDX;
		end
		if (!tin_flags.old_have || (stamp_q < tin_old_stamp)) begin
			nflags.old_have = 1'b1;
			nflags.old_ref  = ref_q;
			nold_idx        = MY_IDX;
			nold_stamp      = stamp_q;
			nold_page       = page_q;
		end
	end

	// token register towards the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tout_flags <= '0;
		end else begin
			tout_flags <= nflags;
		end
	end

	always_ff @(posedge clk) begin
		tout_page      <= tin_page;
		tout_hit_idx   <= nhit_idx;
		tout_free_idx  <= nfree_idx;
		tout_old_idx   <= nold_idx;
		tout_old_stamp <= nold_stamp;
		tout_old_page  <= nold_page;
	end

endmodule

/* rtl/core/pfr_ctrl.sv */
// ----------------------------------------------------------------------------
// pfr_ctrl: request sequencer
// launches tokens into the frame chain, decides on the summary at its tail,
// issues frame writes, keeps the time counter and the result register
// ----------------------------------------------------------------------------
module pfr_ctrl #(
	parameter int FRAMES     = 4,
	parameter int PAGE_BITS  = 16,
	parameter int STAMP_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	pfr_req_if.sink                           req,
	pfr_res_if.source                         res,
	pfr_cfg_if.sink                           cfg,
	output pfr_pkg::pfr_tok_flags_t           head_flags,
	output logic [PAGE_BITS-1:0]              head_page,
	input  pfr_pkg::pfr_tok_flags_t           tail_flags,
	input  logic [$clog2(FRAMES)-1:0]         tail_hit_idx,
	input  logic [$clog2(FRAMES)-1:0]         tail_free_idx,
	input  logic [$clog2(FRAMES)-1:0]         tail_old_idx,
	input  logic [PAGE_BITS-1:0]              tail_old_page,
	output pfr_pkg::pfr_cmd_flags_t           cmd_flags,
	output logic [$clog2(FRAMES)-1:0]         cmd_idx,
	output logic [PAGE_BITS-1:0]              cmd_page,
	output logic [STAMP_BITS-1:0]             cmd_stamp
);
	import pfr_pkg::*;

	localparam int FB = $clog2(FRAMES);

	pfr_state_t               state_q, state_n;
	logic [POLICY_BITS-1:0]   policy_q;
	logic [STAMP_BITS-1:0]    time_q, time_n, time_inc;
	logic [PAGE_BITS-1:0]     page_q;
	logic                     accept, decide, finish, load, out_free;

	logic [OUTCOME_BITS-1:0]  dec_outcome;
	logic [FB-1:0]            dec_frame;
	logic [PAGE_BITS-1:0]     dec_evicted;

	logic                     oval_q;
	logic [OUTCOME_BITS-1:0]  oout_q, pout_q;
	logic [FB-1:0]            ofrm_q, pfrm_q;
	logic [PAGE_BITS-1:0]     oev_q, pev_q;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign decide    = (state_q == S_WAIT) && tail_flags.valid;
	assign out_free  = !oval_q || res.ready;
	assign time_inc  = time_q + STAMP_BITS'(1);

	always_comb begin
		head_flags       = '0;
		head_flags.valid = accept || (state_q == S_LAUNCH);
		head_page        = (state_q == S_IDLE) ? req.page : page_q;
	end

	// decision on the chain summary
	always_comb begin
		state_n     = state_q;
		time_n      = time_q;
		cmd_flags   = '0;
		cmd_idx     = tail_old_idx;
		cmd_page    = page_q;
		cmd_stamp   = time_inc;
		dec_outcome = OUT_HIT;
		dec_frame   = tail_hit_idx;
		dec_evicted = '0;
		finish      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					time_n  = time_inc;
					state_n = S_WAIT;
				end
			end
			S_LAUNCH: begin
				state_n = S_WAIT;
			end
			S_WAIT: begin
				if (decide) begin
					cmd_flags.en = 1'b1;
					if (tail_flags.hit) begin
						cmd_idx   = tail_hit_idx;
						cmd_stamp = time_q;
						cmd_flags.wr_stamp = (policy_q == POL_LRU);
						cmd_flags.wr_ref   = (policy_q == POL_SC);
						cmd_flags.ref_val  = 1'b1;
						finish    = 1'b1;
					end else if (tail_flags.free) begin
						cmd_idx            = tail_free_idx;
						cmd_flags.fill     = 1'b1;
						cmd_flags.wr_stamp = 1'b1;
						time_n      = time_inc;
						dec_outcome = OUT_FREE;
						dec_frame   = tail_free_idx;
						finish      = 1'b1;
					end else if ((policy_q == POL_SC) && tail_flags.old_ref) begin
						// second chance: clear, restamp as newest and look again
						cmd_flags.wr_stamp = 1'b1;
						cmd_flags.wr_ref   = 1'b1;
						cmd_flags.ref_val  = 1'b0;
						time_n  = time_inc;
						state_n = S_LAUNCH;
					end else begin
						cmd_flags.fill     = 1'b1;
						cmd_flags.wr_stamp = 1'b1;
						time_n      = time_inc;
						dec_outcome = OUT_EVICT;
						dec_frame   = tail_old_idx;
						dec_evicted = tail_old_page;
						finish      = 1'b1;
					end
					if (finish) begin
						state_n = out_free ? S_IDLE : S_EMIT;
					end
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign load = (finish && out_free) || ((state_q == S_EMIT) && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			policy_q <= POL_SC;
			time_q   <= STAMP_BITS'(FRAMES);
			oval_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			time_q  <= time_n;
			if (cfg.valid && cfg.ready) begin
				policy_q <= cfg.policy;
			end
			if (load) begin
				oval_q <= 1'b1;
			end else if (res.ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= req.page;
		end
		if (finish) begin
			pout_q <= dec_outcome;
			pfrm_q <= dec_frame;
			pev_q  <= dec_evicted;
		end
		if (load) begin
			oout_q <= finish ? dec_outcome : pout_q;
			ofrm_q <= finish ? dec_frame   : pfrm_q;
			oev_q  <= finish ? dec_evicted : pev_q;
		end
	end

	assign res.valid        = oval_q;
	assign res.outcome      = oout_q;
	assign res.frame        = ofrm_q;
	assign res.evicted_page = oev_q;

endmodule

/* rtl/core/page_frame_replacement.sv */
// ----------------------------------------------------------------------------
// page_frame_replacement: page replacement unit over a chain of frame cells
// fifo, lru and second chance policies over FRAMES frames
//
//   channel  dir  handshake        payload
//   req      in   valid/ready      page
//   res      out  valid/ready      outcome, frame, evicted_page
//   cfg      in   valid/ready      policy (always ready)
//
// from accept to result register, one token walks the chain one cell per
// cycle, then the controller decides on the summary at the tail
// each second chance skip sends a fresh token down the chain, at most
// FRAMES skips per request
// reset: all frames empty, stamps frame index plus one, policy second chance
// a result still waiting on res leaves the next result parked until the
// output frees up; req is taken only when no request is in flight
// ----------------------------------------------------------------------------
module page_frame_replacement #(
	parameter int FRAMES     = 4,
	parameter int PAGE_BITS  = 16,
	parameter int STAMP_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	pfr_req_if.sink    req,
	pfr_res_if.source  res,
	pfr_cfg_if.sink    cfg
);
	import pfr_pkg::*;

	localparam int FB = $clog2(FRAMES);

	// links of the chain: entry i feeds cell i, entry FRAMES is the tail
	pfr_tok_flags_t        t_flags     [FRAMES+1];
	logic [PAGE_BITS-1:0]  t_page      [FRAMES+1];
	logic [FB-1:0]         t_hit_idx   [FRAMES+1];
	logic [FB-1:0]         t_free_idx  [FRAMES+1];
	logic [FB-1:0]         t_old_idx   [FRAMES+1];
	logic [STAMP_BITS-1:0] t_old_stamp [FRAMES+1];
	logic [PAGE_BITS-1:0]  t_old_page  [FRAMES+1];

	// write command broadcast to every cell
	pfr_cmd_flags_t        cmd_flags;
	logic [FB-1:0]         cmd_idx;
	logic [PAGE_BITS-1:0]  cmd_page;
	logic [STAMP_BITS-1:0] cmd_stamp;

	// head of the chain starts with an empty summary
	assign t_hit_idx[0]   = '0;
	assign t_free_idx[0]  = '0;
	assign t_old_idx[0]   = '0;
	assign t_old_stamp[0] = '0;
	assign t_old_page[0]  = '0;

	pfr_ctrl #(
		.FRAMES     (FRAMES),
		.PAGE_BITS  (PAGE_BITS),
		.STAMP_BITS (STAMP_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.res           (res),
		.cfg           (cfg),
		.head_flags    (t_flags[0]),
		.head_page     (t_page[0]),
		.tail_flags    (t_flags[FRAMES]),
		.tail_hit_idx  (t_hit_idx[FRAMES]),
		.tail_free_idx (t_free_idx[FRAMES]),
		.tail_old_idx  (t_old_idx[FRAMES]),
		.tail_old_page (t_old_page[FRAMES]),
		.cmd_flags     (cmd_flags),
		.cmd_idx       (cmd_idx),
		.cmd_page      (cmd_page),
		.cmd_stamp     (cmd_stamp)
	);

	// row of frame cells, lowest index first so ties go to it
	for (genvar i = 0; i < FRAMES; i++) begin : g_cell
		pfr_cell #(
			.FRAMES     (FRAMES),
			.PAGE_BITS  (PAGE_BITS),
			.STAMP_BITS (STAMP_BITS),
			.IDX        (i)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.tin_flags      (t_flags[i]),
			.tin_page       (t_page[i]),
			.tin_hit_idx    (t_hit_idx[i]),
			.tin_free_idx   (t_free_idx[i]),
			.tin_old_idx    (t_old_idx[i]),
			.tin_old_stamp  (t_old_stamp[i]),
			.tin_old_page   (t_old_page[i]),
			.tout_flags     (t_flags[i+1]),
			.tout_page      (t_page[i+1]),
			.tout_hit_idx   (t_hit_idx[i+1]),
			.tout_free_idx  (t_free_idx[i+1]),
			.tout_old_idx   (t_old_idx[i+1]),
			.tout_old_stamp (t_old_stamp[i+1]),
			.tout_old_page  (t_old_page[i+1]),
			.cmd_flags      (cmd_flags),
			.cmd_idx        (cmd_idx),
			.cmd_page       (cmd_page),
			.cmd_stamp      (cmd_stamp)
		);
	end

endmodule
